### src/fps_pkg.sv
package fps_pkg;

	localparam int NUM_STAGES = 10;
	localparam int CHAN_W = 8;
	localparam int MODE_W = 3;
	localparam int FACTOR_W = 17;
	// 1.0 on the factor input
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

	typedef enum logic [MODE_W-1:0] {
		MODE_GREY     = 3'd0,
		MODE_INV_GREY = 3'd1,
		MODE_SWEEP    = 3'd2,
		MODE_RAMP     = 3'd3
	} palette_mode_t;

	typedef enum logic [2:0] {
		SECT_RED     = 3'd0,
		SECT_YELLOW  = 3'd1,
		SECT_GREEN   = 3'd2,
		SECT_CYAN    = 3'd3,
		SECT_BLUE    = 3'd4,
		SECT_MAGENTA = 3'd5
	} hue_sector_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic              use_grey;
		logic [CHAN_W-1:0] level;
	} grey_tag_t;

	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	// adv[i]: stage i+1 loads this cycle; vld[i]: stage i+1 holds an item
	typedef struct packed {
		stage_vec_t adv;
		stage_vec_t vld;
	} pipe_ctrl_t;

endpackage

### src/fps_front.sv
module fps_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fps_pkg::pipe_ctrl_t             ctrl,
	input  logic [fps_pkg::FACTOR_W-1:0]    factor,
	input  logic [fps_pkg::MODE_W-1:0]      palette_mode,
	output logic [FRAC_BITS+8:0]            hue,
	output logic [FRAC_BITS:0]              sat,
	output logic [FRAC_BITS:0]              val,
	output fps_pkg::grey_tag_t              grey
);

	localparam int FB = FRAC_BITS;
	localparam int FW = FB + 1;
	localparam int HW = FB + 9;
	localparam int XW = FB + 10;
	localparam int RW = FB + 3;
	localparam int KW = 2 * FB + 3;
	localparam int PW = 2 * FB + 1;
	localparam int GW = FB + 9;

	localparam logic [63:0] ONE    = 64'd1 << FB;
	localparam logic [63:0] STOP   = (ONE * 64'd60) / 64'd100;
	localparam logic [63:0] D_HI   = ONE - STOP;
	localparam logic [63:0] MS     = (ONE * 64'd80) / 64'd100;
	localparam logic [63:0] MV     = (ONE * 64'd20) / 64'd100;
	localparam logic [63:0] CS     = (ONE * 64'd90) / 64'd100;
	localparam logic [63:0] CV     = (ONE * 64'd80) / 64'd100;
	localparam logic [63:0] DS     = CS - MS;
	localparam logic [63:0] DV     = CV - MV;
	localparam logic [63:0] H_MID  = ONE * 64'd250;
	localparam logic [63:0] H_CHE  = ONE * 64'd315;
	localparam logic [63:0] H_OFF  = ONE * 64'd300;
	localparam logic [63:0] FULL   = ONE * 64'd360;
	localparam logic [63:0] FULL2  = ONE * 64'd720;
	localparam logic [63:0] S_BASE = (ONE * 64'd3) / 64'd4;
	// reciprocals for the ramp position, estimate is low by at most one
	localparam logic [63:0] R_LO   = (64'd1 << (2 * FB + 1)) / STOP;
	localparam logic [63:0] R_HI   = (64'd1 << (2 * FB + 1)) / D_HI;

	// stage 1: saturate and rescale the factor, pick ramp segment
	logic [fps_pkg::FACTOR_W-1:0] raw;
	logic [FW-1:0] f_n;
	logic br_n;
	logic [FB-1:0] d_n;

	logic [FW-1:0] f_s1;
	logic [fps_pkg::MODE_W-1:0] mode_s1;
	logic br_s1;
	logic [FB-1:0] d_s1;

	assign raw  = (factor > fps_pkg::FACTOR_ONE) ? fps_pkg::FACTOR_ONE : factor;
	assign f_n  = FW'({raw, {FB{1'b0}}} >> 16);
	assign br_n = f_n > FW'(STOP);
	assign d_n  = br_n ? FB'(f_n - FW'(STOP)) : FB'(f_n);

	always_ff @(posedge clk) begin
		if (ctrl.adv[0]) begin
			f_s1    <= f_n;
			mode_s1 <= palette_mode;
			br_s1   <= br_n;
			d_s1    <= d_n;
		end
	end

	// stage 2: grey level, sweep hue, ramp position estimate
	logic [FW-1:0] g;
	logic [FW-1:0] grey_src;
	logic [GW-1:0] grey_prod;
	logic [RW-1:0] recip;
	logic [KW-1:0] k_prod;
	logic [XW-1:0] hraw_n;
	logic [FW-1:0] ssw_n;
	fps_pkg::grey_tag_t grey_n;

	logic [FW-1:0] kest_s2;
	logic [FB-1:0] d_s2;
	logic br_s2;
	logic [XW-1:0] hraw_s2;
	logic [FW-1:0] ssw_s2;
	logic ramp_s2;
	fps_pkg::grey_tag_t grey_s2;

	assign g         = FW'(ONE) - f_s1;
	assign grey_src  = (mode_s1 == fps_pkg::MODE_INV_GREY) ? f_s1 : g;
	assign grey_prod = GW'(grey_src) * GW'(255);
	assign grey_n.level    = fps_pkg::CHAN_W'(grey_prod >> FB);
	assign grey_n.use_grey = !((mode_s1 == fps_pkg::MODE_SWEEP) ||
		(mode_s1 == fps_pkg::MODE_RAMP));
	assign recip  = br_s1 ? RW'(R_HI) : RW'(R_LO);
	assign k_prod = KW'(d_s1) * KW'(recip);
	assign hraw_n = XW'(g) * XW'(720) + XW'(H_OFF);
	assign ssw_n  = FW'(S_BASE) + FW'(g >> 2);

	always_ff @(posedge clk) begin
		if (ctrl.adv[1]) begin
			kest_s2 <= FW'(k_prod >> (FB + 1));
			d_s2    <= d_s1;
			br_s2   <= br_s1;
			hraw_s2 <= hraw_n;
			ssw_s2  <= ssw_n;
			ramp_s2 <= (mode_s1 == fps_pkg::MODE_RAMP);
			grey_s2 <= grey_n;
		end
	end

	// stage 3: correct the position estimate, wrap the sweep hue
	logic [FB-1:0] den;
	logic [FW-1:0] kinc;
	logic [PW-1:0] chk;
	logic [PW-1:0] num;
	logic [FW-1:0] k_n;
	logic [HW-1:0] hmod_n;

	logic [FW-1:0] k_s3;
	logic br_s3;
	logic [HW-1:0] hmod_s3;
	logic [FW-1:0] ssw_s3;
	logic ramp_s3;
	fps_pkg::grey_tag_t grey_s3;

	assign den  = br_s2 ? FB'(D_HI) : FB'(STOP);
	assign kinc = kest_s2 + FW'(1);
	assign chk  = PW'(kinc) * PW'(den);
	assign num  = PW'({d_s2, {FB{1'b0}}});
	assign k_n  = (num >= chk) ? kinc : kest_s2;

	always_comb begin
		if (hraw_s2 >= XW'(FULL2)) begin
			hmod_n = HW'(hraw_s2 - XW'(FULL2));
		end else if (hraw_s2 >= XW'(FULL)) begin
			hmod_n = HW'(hraw_s2 - XW'(FULL));
		end else begin
			hmod_n = HW'(hraw_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv[2]) begin
			k_s3    <= k_n;
			br_s3   <= br_s2;
			hmod_s3 <= hmod_n;
			ssw_s3  <= ssw_s2;
			ramp_s3 <= ramp_s2;
			grey_s3 <= grey_s2;
		end
	end

	// stage 4: interpolate H, S, V along the ramp and pick the palette
	logic [HW-1:0] ph;
	logic [PW-1:0] ps_prod;
	logic [PW-1:0] pv_prod;
	logic [FW-1:0] ps;
	logic [FW-1:0] pv;
	logic [HW-1:0] h_n;
	logic [FW-1:0] s_n;
	logic [FW-1:0] v_n;

	logic [HW-1:0] h_s4;
	logic [FW-1:0] s_s4;
	logic [FW-1:0] v_s4;
	fps_pkg::grey_tag_t grey_s4;

	assign ph      = HW'(k_s3) * HW'(65);
	assign ps_prod = PW'(k_s3) * PW'(DS);
	assign pv_prod = PW'(k_s3) * PW'(DV);
	assign ps      = FW'(ps_prod >> FB);
	assign pv      = FW'(pv_prod >> FB);

	always_comb begin
		if (!ramp_s3) begin
			h_n = hmod_s3;
			s_n = ssw_s3;
			v_n = FW'(ONE);
		end else if (br_s3) begin
			h_n = HW'(H_CHE) - ph;
			s_n = FW'(CS) - ps;
			v_n = FW'(CV) - pv;
		end else begin
			h_n = HW'(H_MID) + ph;
			s_n = FW'(MS) + ps;
			v_n = FW'(MV) + pv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv[3]) begin
			h_s4    <= h_n;
			s_s4    <= s_n;
			v_s4    <= v_n;
			grey_s4 <= grey_s3;
		end
	end

	assign hue  = h_s4;
	assign sat  = s_s4;
	assign val  = v_s4;
	assign grey = grey_s4;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[2] |-> k_s3 <= FW'(ONE))
		else $error("ramp position above 1.0");

	a_hue_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[2] |-> hmod_s3 < HW'(FULL))
		else $error("sweep hue not wrapped below 360");

endmodule

### src/fps_hsv.sv
module fps_hsv #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fps_pkg::pipe_ctrl_t  ctrl,
	input  logic [FRAC_BITS+8:0] hue,
	input  logic [FRAC_BITS:0]   sat,
	input  logic [FRAC_BITS:0]   val,
	input  fps_pkg::grey_tag_t   grey,
	output fps_pkg::pixel_t      pix
);

	localparam int FB  = FRAC_BITS;
	localparam int FW  = FB + 1;
	localparam int HW  = FB + 9;
	localparam int EW  = FB + 6;
	localparam int RMW = FB + 1;
	localparam int MW  = EW + RMW;
	localparam int PW2 = 2 * FB + 2;
	localparam int CW  = FB + 9;

	localparam logic [63:0] ONE = 64'd1 << FB;
	localparam logic [63:0] SEG = ONE * 64'd60;
	localparam logic [63:0] R60 = (64'd1 << (FB + 6)) / 64'd60;

	function automatic logic [fps_pkg::CHAN_W-1:0] chan(input logic [FW-1:0] x);
		logic [CW-1:0] prod;
		prod = CW'(x) * CW'(255);
		return fps_pkg::CHAN_W'(prod >> FB);
	endfunction

	// stage 5: sector by compares, offset into sector, p
	fps_pkg::hue_sector_t sect_n;
	logic [HW-1:0] base_n;
	logic [PW2-1:0] p_prod;

	fps_pkg::hue_sector_t sect_s5;
	logic [EW-1:0] rem_s5;
	logic [FW-1:0] sat_s5;
	logic [FW-1:0] val_s5;
	logic [FW-1:0] p_s5;
	fps_pkg::grey_tag_t grey_s5;

	always_comb begin
		if (hue >= HW'(SEG * 64'd5)) begin
			sect_n = fps_pkg::SECT_MAGENTA;
			base_n = HW'(SEG * 64'd5);
		end else if (hue >= HW'(SEG * 64'd4)) begin
			sect_n = fps_pkg::SECT_BLUE;
			base_n = HW'(SEG * 64'd4);
		end else if (hue >= HW'(SEG * 64'd3)) begin
			sect_n = fps_pkg::SECT_CYAN;
			base_n = HW'(SEG * 64'd3);
		end else if (hue >= HW'(SEG * 64'd2)) begin
			sect_n = fps_pkg::SECT_GREEN;
			base_n = HW'(SEG * 64'd2);
		end else if (hue >= HW'(SEG)) begin
			sect_n = fps_pkg::SECT_YELLOW;
			base_n = HW'(SEG);
		end else begin
			sect_n = fps_pkg::SECT_RED;
			base_n = '0;
		end
	end

	assign p_prod = PW2'(val) * PW2'(FW'(ONE) - sat);

	always_ff @(posedge clk) begin
		if (ctrl.adv[4]) begin
			sect_s5 <= sect_n;
			rem_s5  <= EW'(hue - base_n);
			sat_s5  <= sat;
			val_s5  <= val;
			p_s5    <= FW'(p_prod >> FB);
			grey_s5 <= grey;
		end
	end

	// stage 6: offset / 60 by reciprocal, low by at most one
	logic [MW-1:0] ff_prod;

	logic [FB-1:0] ffe_s6;
	logic [EW-1:0] rem_s6;
	fps_pkg::hue_sector_t sect_s6;
	logic [FW-1:0] sat_s6;
	logic [FW-1:0] val_s6;
	logic [FW-1:0] p_s6;
	fps_pkg::grey_tag_t grey_s6;

	assign ff_prod = MW'(rem_s5) * MW'(RMW'(R60));

	always_ff @(posedge clk) begin
		if (ctrl.adv[5]) begin
			ffe_s6  <= FB'(ff_prod >> (FB + 6));
			rem_s6  <= rem_s5;
			sect_s6 <= sect_s5;
			sat_s6  <= sat_s5;
			val_s6  <= val_s5;
			p_s6    <= p_s5;
			grey_s6 <= grey_s5;
		end
	end

	// stage 7: correct the quotient
	logic [FW-1:0] ffi;
	logic [EW-1:0] ff_chk;
	logic [FB-1:0] ff_n;

	logic [FB-1:0] ff_s7;
	fps_pkg::hue_sector_t sect_s7;
	logic [FW-1:0] sat_s7;
	logic [FW-1:0] val_s7;
	logic [FW-1:0] p_s7;
	fps_pkg::grey_tag_t grey_s7;

	assign ffi    = FW'(ffe_s6) + FW'(1);
	assign ff_chk = EW'(ffi) * EW'(60);
	assign ff_n   = (ff_chk <= rem_s6) ? FB'(ffi) : ffe_s6;

	always_ff @(posedge clk) begin
		if (ctrl.adv[6]) begin
			ff_s7   <= ff_n;
			sect_s7 <= sect_s6;
			sat_s7  <= sat_s6;
			val_s7  <= val_s6;
			p_s7    <= p_s6;
			grey_s7 <= grey_s6;
		end
	end

	// stage 8: s*ff and s*(1-ff)
	logic [PW2-1:0] a_prod;
	logic [PW2-1:0] b_prod;

	logic [FW-1:0] a_s8;
	logic [FW-1:0] b_s8;
	fps_pkg::hue_sector_t sect_s8;
	logic [FW-1:0] val_s8;
	logic [FW-1:0] p_s8;
	fps_pkg::grey_tag_t grey_s8;

	assign a_prod = PW2'(sat_s7) * PW2'(ff_s7);
	assign b_prod = PW2'(sat_s7) * PW2'(FW'(ONE) - FW'(ff_s7));

	always_ff @(posedge clk) begin
		if (ctrl.adv[7]) begin
			a_s8    <= FW'(a_prod >> FB);
			b_s8    <= FW'(b_prod >> FB);
			sect_s8 <= sect_s7;
			val_s8  <= val_s7;
			p_s8    <= p_s7;
			grey_s8 <= grey_s7;
		end
	end

	// stage 9: q and t
	logic [PW2-1:0] q_prod;
	logic [PW2-1:0] t_prod;

	logic [FW-1:0] q_s9;
	logic [FW-1:0] t_s9;
	fps_pkg::hue_sector_t sect_s9;
	logic [FW-1:0] val_s9;
	logic [FW-1:0] p_s9;
	fps_pkg::grey_tag_t grey_s9;

	assign q_prod = PW2'(val_s8) * PW2'(FW'(ONE) - a_s8);
	assign t_prod = PW2'(val_s8) * PW2'(FW'(ONE) - b_s8);

	always_ff @(posedge clk) begin
		if (ctrl.adv[8]) begin
			q_s9    <= FW'(q_prod >> FB);
			t_s9    <= FW'(t_prod >> FB);
			sect_s9 <= sect_s8;
			val_s9  <= val_s8;
			p_s9    <= p_s8;
			grey_s9 <= grey_s8;
		end
	end

	// stage 10: scale to 8 bits and route by sector, or pass the grey level; output register
	logic [fps_pkg::CHAN_W-1:0] cv;
	logic [fps_pkg::CHAN_W-1:0] cp;
	logic [fps_pkg::CHAN_W-1:0] cq;
	logic [fps_pkg::CHAN_W-1:0] ct;
	fps_pkg::pixel_t pix_n;
	fps_pkg::pixel_t pix_s10;

	assign cv = chan(val_s9);
	assign cp = chan(p_s9);
	assign cq = chan(q_s9);
	assign ct = chan(t_s9);

	always_comb begin
		if (grey_s9.use_grey) begin
			pix_n = '{red: grey_s9.level, green: grey_s9.level, blue: grey_s9.level};
		end else begin
			case (sect_s9)
				fps_pkg::SECT_RED: begin
					pix_n = '{red: cv, green: ct, blue: cp};
				end
				fps_pkg::SECT_YELLOW: begin
					pix_n = '{red: cq, green: cv, blue: cp};
				end
				fps_pkg::SECT_GREEN: begin
					pix_n = '{red: cp, green: cv, blue: ct};
				end
				fps_pkg::SECT_CYAN: begin
					pix_n = '{red: cp, green: cq, blue: cv};
				end
				fps_pkg::SECT_BLUE: begin
					pix_n = '{red: ct, green: cp, blue: cv};
				end
				default: begin
					pix_n = '{red: cv, green: cp, blue: cq};
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv[9]) begin
			pix_s10 <= pix_n;
		end
	end

	assign pix = pix_s10;

	a_rem_in_sector: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[4] |-> rem_s5 < EW'(SEG))
		else $error("hue offset outside its sector");

	a_ff_exact: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[5] |-> (EW'(ff_n) * EW'(60) <= rem_s6) &&
			(rem_s6 < EW'(ff_n) * EW'(60) + EW'(60)))
		else $error("sector fraction quotient off by one");

endmodule

### src/fractal_palette_shader_unit.sv
// Ten register stages; a result shows on out_valid once its accepted item has
// passed through all of them, the tenth stage being the output register.
// Throughput: one item per cycle while out_ready is high; each stage stalls only
// when it is full and the stage after it cannot load, so bubbles are squeezed out.
// Reset (arst_n low): all stage valid bits clear and palette_mode returns to
// greyscale; datapath registers are not reset.
module fractal_palette_shader_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fps_pkg::FACTOR_W-1:0] factor,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fps_pkg::CHAN_W-1:0]   red,
	output logic [fps_pkg::CHAN_W-1:0]   green,
	output logic [fps_pkg::CHAN_W-1:0]   blue,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fps_pkg::MODE_W-1:0]   cfg_data
);

	localparam int NS = fps_pkg::NUM_STAGES;

	logic [fps_pkg::MODE_W-1:0] palette_mode_q;
	fps_pkg::stage_vec_t vld_q;
	fps_pkg::stage_vec_t adv;
	fps_pkg::pipe_ctrl_t ctrl;

	logic [FRAC_BITS+8:0] hue;
	logic [FRAC_BITS:0]   sat;
	logic [FRAC_BITS:0]   val;
	fps_pkg::grey_tag_t   grey;
	fps_pkg::pixel_t      pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_mode_q <= fps_pkg::MODE_GREY;
		end else if (cfg_valid && cfg_ready) begin
			palette_mode_q <= cfg_data;
		end
	end

	// a stage loads when it is empty or the next one loads too
	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || out_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (adv & {vld_q[NS-2:0], in_valid}) | (~adv & vld_q);
		end
	end

	assign ctrl.adv  = adv;
	assign ctrl.vld  = vld_q;
	assign in_ready  = adv[0];
	assign out_valid = vld_q[NS-1];

	fps_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.factor      (factor),
		.palette_mode(palette_mode_q),
		.hue         (hue),
		.sat         (sat),
		.val         (val),
		.grey        (grey)
	);

	fps_hsv #(
		.FRAC_BITS(FRAC_BITS)
	) u_hsv (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.hue   (hue),
		.sat   (sat),
		.val   (val),
		.grey  (grey),
		.pix   (pix)
	);

	assign red   = pix.red;
	assign green = pix.green;
	assign blue  = pix.blue;

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_q)
		else $error("input blocked with a bubble in the pipeline");

	a_item_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item not held in first stage");

endmodule

### tb/fractal_palette_shader_unit_tb.sv
`timescale 1ns / 1ps

module fractal_palette_shader_unit_tb;

	localparam int FRAC = 16;
	localparam int FACTOR_FRAC = 16;
	localparam longint UNITY = longint'(1) << FRAC;

	// palette constants, floor(c * UNITY)
	localparam longint MID_H = 250 * UNITY;
	localparam longint MID_S = (80 * UNITY) / 100;
	localparam longint MID_V = (20 * UNITY) / 100;
	localparam longint CHE_H = 315 * UNITY;
	localparam longint CHE_S = (90 * UNITY) / 100;
	localparam longint CHE_V = (80 * UNITY) / 100;
	localparam longint RAMP_STOP = (60 * UNITY) / 100;

	// mode values with no palette of their own; they shade as grey
	localparam logic [fps_pkg::MODE_W-1:0] MODE_SPARE_4 = 3'd4;
	localparam logic [fps_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [fps_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [fps_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	localparam logic [fps_pkg::FACTOR_W-1:0] STOP_FACTOR = 17'd39321;
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int ROUND_ITEMS = 100;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [fps_pkg::MODE_W-1:0]   mode;
		logic [fps_pkg::FACTOR_W-1:0] val;
		logic                         known;
		fps_pkg::pixel_t              pix;
	} shade_row_t;

	localparam fps_pkg::pixel_t PIX_WHITE = '{8'd255, 8'd255, 8'd255};
	localparam fps_pkg::pixel_t PIX_BLACK = '{8'd0, 8'd0, 8'd0};
	localparam fps_pkg::pixel_t PIX_MAGENTA = '{8'd255, 8'd0, 8'd255};
	localparam fps_pkg::pixel_t PIX_PINK = '{8'd255, 8'd63, 8'd255};

	localparam int DIRECTED_COUNT = 25;
	localparam shade_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
		'{fps_pkg::MODE_GREY, 17'd0, 1'b1, PIX_WHITE},
		'{fps_pkg::MODE_GREY, 17'd65536, 1'b1, PIX_BLACK},
		'{fps_pkg::MODE_GREY, 17'd131071, 1'b1, PIX_BLACK},
		'{fps_pkg::MODE_GREY, 17'd32768, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_GREY, 17'd65537, 1'b1, PIX_BLACK},
		'{fps_pkg::MODE_INV_GREY, 17'd0, 1'b1, PIX_BLACK},
		'{fps_pkg::MODE_INV_GREY, 17'd65536, 1'b1, PIX_WHITE},
		'{fps_pkg::MODE_INV_GREY, 17'd98304, 1'b1, PIX_WHITE},
		'{fps_pkg::MODE_INV_GREY, 17'd1, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_SWEEP, 17'd0, 1'b1, PIX_MAGENTA},
		'{fps_pkg::MODE_SWEEP, 17'd65536, 1'b1, PIX_PINK},
		'{fps_pkg::MODE_SWEEP, 17'd131071, 1'b1, PIX_PINK},
		'{fps_pkg::MODE_SWEEP, 17'd21845, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_SWEEP, 17'd43690, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_SWEEP, 17'd10923, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_RAMP, 17'd0, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_RAMP, 17'd39321, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_RAMP, 17'd39322, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_RAMP, 17'd65536, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_RAMP, 17'd1, 1'b0, PIX_BLACK},
		'{fps_pkg::MODE_RAMP, 17'd131071, 1'b0, PIX_BLACK},
		'{MODE_SPARE_4, 17'd0, 1'b1, PIX_WHITE},
		'{MODE_SPARE_5, 17'd65536, 1'b1, PIX_BLACK},
		'{MODE_SPARE_6, 17'd16384, 1'b0, PIX_BLACK},
		'{MODE_SPARE_7, 17'd131071, 1'b1, PIX_BLACK}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [fps_pkg::FACTOR_W-1:0] factor;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [fps_pkg::CHAN_W-1:0]   red;
	logic [fps_pkg::CHAN_W-1:0]   green;
	logic [fps_pkg::CHAN_W-1:0]   blue;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [fps_pkg::MODE_W-1:0]   cfg_data;

	fps_pkg::pixel_t            pending_pixels [$];
	fps_pkg::pixel_t            head_pixel;
	logic [fps_pkg::MODE_W-1:0] mode_plan [$];
	logic [fps_pkg::MODE_W-1:0] active_mode;
	int                         fail_count = 0;
	int                         stuck_cycles = 0;
	int                         send_idle_pct = 0;
	int                         rx_stall_pct = 0;
	logic                       hold_ask = 1'b0;
	logic                       hold_seen = 1'b0;
	int                         hold_left = 0;

	fractal_palette_shader_unit #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.factor    (factor),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// signed product, truncated toward zero
	function automatic longint mul_trunc(longint a, longint b);
		u64_t ma, mb, mag;
		ma = (a < 0) ? u64_t'(-a) : u64_t'(a);
		mb = (b < 0) ? u64_t'(-b) : u64_t'(b);
		mag = (ma * mb) >> FRAC;
		return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [fps_pkg::CHAN_W-1:0] chan8(longint x);
		longint lvl;
		if (x < 0)
			x = 0;
		if (x > UNITY)
			x = UNITY;
		lvl = (x * 255) >> FRAC;
		return lvl[fps_pkg::CHAN_W-1:0];
	endfunction

	function automatic longint blend(longint a, longint b, longint k);
		return a + mul_trunc(k, b - a);
	endfunction

	function automatic fps_pkg::pixel_t hsv_pixel(longint h, longint s, longint v);
		longint sector, ff, p, q, t;
		logic [fps_pkg::CHAN_W-1:0] cv, cp, cq, ct;
		fps_pkg::pixel_t px;
		h = h % (360 * UNITY);
		if (h < 0)
			h += 360 * UNITY;
		sector = h / (60 * UNITY);
		ff = (h - sector * 60 * UNITY) / 60;
		p = mul_trunc(v, UNITY - s);
		q = mul_trunc(v, UNITY - mul_trunc(s, ff));
		t = mul_trunc(v, UNITY - mul_trunc(s, UNITY - ff));
		cv = chan8(v);
		cp = chan8(p);
		cq = chan8(q);
		ct = chan8(t);
		case (sector[2:0])
			fps_pkg::SECT_RED:    px = '{cv, ct, cp};
			fps_pkg::SECT_YELLOW: px = '{cq, cv, cp};
			fps_pkg::SECT_GREEN:  px = '{cp, cv, ct};
			fps_pkg::SECT_CYAN:   px = '{cp, cq, cv};
			fps_pkg::SECT_BLUE:   px = '{ct, cp, cv};
			default:              px = '{cv, cp, cq};
		endcase
		return px;
	endfunction

	function automatic fps_pkg::pixel_t ramp_pixel(longint f);
		longint k;
		if (f <= 0)
			return hsv_pixel(MID_H, MID_S, MID_V);
		if (f <= RAMP_STOP) begin
			k = (f * UNITY) / RAMP_STOP;
			return hsv_pixel(blend(MID_H, CHE_H, k), blend(MID_S, CHE_S, k),
				blend(MID_V, CHE_V, k));
		end
		k = ((f - RAMP_STOP) * UNITY) / (UNITY - RAMP_STOP);
		return hsv_pixel(blend(CHE_H, MID_H, k), blend(CHE_S, MID_S, k),
			blend(CHE_V, MID_V, k));
	endfunction

	function automatic fps_pkg::pixel_t shade_pixel(logic [fps_pkg::MODE_W-1:0] mode,
			logic [fps_pkg::FACTOR_W-1:0] val);
		longint f, g;
		logic [fps_pkg::CHAN_W-1:0] level;
		f = (val > fps_pkg::FACTOR_ONE) ? longint'(fps_pkg::FACTOR_ONE) : longint'(val);
		f = (f << FRAC) >> FACTOR_FRAC;
		g = UNITY - f;
		case (mode)
			fps_pkg::MODE_INV_GREY: begin
				level = chan8(f);
				return '{level, level, level};
			end
			fps_pkg::MODE_SWEEP: return hsv_pixel(720 * g + 300 * UNITY,
				(3 * UNITY) / 4 + (g >>> 2), UNITY);
			fps_pkg::MODE_RAMP:  return ramp_pixel(f);
			default: begin
				level = chan8(g);
				return '{level, level, level};
			end
		endcase
	endfunction

	function automatic logic [fps_pkg::FACTOR_W-1:0] pick_factor();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(7))
			0: return r[fps_pkg::FACTOR_W-1:0];
			1: return fps_pkg::FACTOR_W'(fps_pkg::FACTOR_ONE - $urandom_range(2));
			2: return fps_pkg::FACTOR_W'(STOP_FACTOR + $urandom_range(4) - 2);
			default: return fps_pkg::FACTOR_W'($urandom_range(fps_pkg::FACTOR_ONE));
		endcase
	endfunction

	task automatic send_factor(input logic [fps_pkg::FACTOR_W-1:0] val,
			input fps_pkg::pixel_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		factor   <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_pixels.push_back(want);
	endtask

	// palette changes only once the pipe has emptied
	task automatic write_mode(input logic [fps_pkg::MODE_W-1:0] mode);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (fps_pkg::NUM_STAGES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid   <= 1'b0;
		active_mode = mode;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$error("pixel %0d/%0d/%0d with nothing expected", red, green, blue);
					fail_count++;
				end else begin
					head_pixel = pending_pixels.pop_front();
					if (red !== head_pixel.red) begin
						$error("red: expected %0d, got %0d", head_pixel.red, red);
						fail_count++;
					end
					if (green !== head_pixel.green) begin
						$error("green: expected %0d, got %0d", head_pixel.green, green);
						fail_count++;
					end
					if (blue !== head_pixel.blue) begin
						$error("blue: expected %0d, got %0d", head_pixel.blue, blue);
						fail_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		logic [fps_pkg::FACTOR_W-1:0] val;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		factor      = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		active_mode = fps_pkg::MODE_GREY;
		mode_plan = '{fps_pkg::MODE_RAMP, fps_pkg::MODE_SWEEP, fps_pkg::MODE_INV_GREY,
			fps_pkg::MODE_GREY, MODE_SPARE_7, fps_pkg::MODE_RAMP, fps_pkg::MODE_SWEEP,
			MODE_SPARE_5, fps_pkg::MODE_RAMP, fps_pkg::MODE_INV_GREY, fps_pkg::MODE_SWEEP,
			fps_pkg::MODE_GREY};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first rows run on the reset palette
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			if (DIRECTED_ROWS[i].mode != active_mode)
				write_mode(DIRECTED_ROWS[i].mode);
			send_factor(DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].pix :
				shade_pixel(active_mode, DIRECTED_ROWS[i].val));
		end

		for (int round = 0; round < mode_plan.size(); round++) begin
			write_mode(mode_plan[round]);
			case (round % 4)
				0: begin
					send_idle_pct = 0;
					rx_stall_pct  = 0;
				end
				1: begin
					send_idle_pct = 58;
					rx_stall_pct  = 0;
				end
				2: begin
					send_idle_pct = 0;
					rx_stall_pct  = 58;
				end
				default: begin
					send_idle_pct = 6;
					rx_stall_pct  = 6;
				end
			endcase
			// back-pressure: output held off while items keep coming
			if (round == 4)
				hold_ask <= ~hold_ask;
			for (int n = 0; n < ROUND_ITEMS; n++) begin
				val = pick_factor();
				send_factor(val, shade_pixel(active_mode, val));
			end
		end

		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (fps_pkg::NUM_STAGES + 4) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
